/* rtl/gfes_pkg.sv */
// ---------------------------------------------------------------------------
// gfes_pkg
// shared constants, command codes and the queue entry type of the group
// fade effect scheduler
// ---------------------------------------------------------------------------
package gfes_pkg;

	// group table
	localparam int NUM_GROUPS  = 16;
	localparam int IDX_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// field widths
	localparam int FUNC_W = 2;
	localparam int GRP_W  = 4;
	localparam int KIND_W = 2;
	localparam int TIME_W = 32;
	localparam int PER_W  = 10;
	localparam int LVL_W  = 8;

	// arithmetic constants
	localparam int                FULL_LEVEL   = 255;
	localparam int                MS_PER_S     = 1000;
	localparam logic [PER_W-1:0]  RESET_PERIOD = 10'd16;

	// command queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// func codes
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

	// effect kinds
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UP     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_STROBE = 2'd3;

	// classified request handed from front to back
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [GRP_W-1:0]  grp;
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] stamp;   // tick: now, apply: next-run time
		logic [PER_W-1:0]  period;
		logic [LVL_W-1:0]  level;
		logic              on;
	} cmd_t;

endpackage

/* rtl/group_fade_effect_scheduler_unit.sv */
// ---------------------------------------------------------------------------
// group_fade_effect_scheduler_unit
// per-group lighting fade engine: apply, set level and tick requests
// ---------------------------------------------------------------------------
// flow: a tick passes the front register and the queue before the back pops it, then
//   the back scans one group per cycle while results can be taken, ending with a flush
//   step; the front takes a new request only once the last is pushed or dropped, and
//   a tick holds the back for its whole scan and flush
// reset: all group state zero, default period 16 ms, queue and output empty;
//   the group table resets in flip-flops, so there is no clearing pass
module group_fade_effect_scheduler_unit
	import gfes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration: default step period
	input  logic              cfg_we,
	input  logic [PER_W-1:0]  cfg_wdata,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [GRP_W-1:0]  group_index,
	input  logic [KIND_W-1:0] effect_kind,
	input  logic [TIME_W-1:0] delay_ms,
	input  logic [PER_W-1:0]  rate_hz,
	input  logic [LVL_W-1:0]  level_value,
	input  logic              on_value,
	input  logic [TIME_W-1:0] now_ms,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [GRP_W-1:0]  out_group,
	output logic [LVL_W-1:0]  out_level,
	output logic              out_on,
	output logic              last
);

	// default period register, read by the front when an apply has no rate
	logic [PER_W-1:0] default_period_q;

	// front to queue
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// queue to back
	logic pop;
	cmd_t head;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_period_q <= RESET_PERIOD;
		end else if (cfg_we) begin
			default_period_q <= cfg_wdata;
		end
	end

	// front: classify, drop no-ops, compute period and next-run time
	gfes_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.group_index    (group_index),
		.effect_kind    (effect_kind),
		.delay_ms       (delay_ms),
		.rate_hz        (rate_hz),
		.level_value    (level_value),
		.on_value       (on_value),
		.now_ms         (now_ms),
		.default_period (default_period_q),
		.push           (push),
		.push_cmd       (push_cmd),
		.q_full         (q_full)
	);

	// short queue decouples the front from a long tick scan
	gfes_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// back: group table, scan and result output
	gfes_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_group (out_group),
		.out_level (out_level),
		.out_on    (out_on),
		.last      (last)
	);

	// queue is never written when full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("push into full queue");

	// queue is never read when empty
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_empty))
		else $error("pop from empty queue");

	// an accepted tick always occupies the front for the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == FUNC_TICK) |=> !in_ready)
		else $error("front ready right after a tick request");

endmodule

/* rtl/gfes_front.sv */
// ---------------------------------------------------------------------------
// gfes_front
// accepts requests, drops the ones that do nothing, works out the step
// period (bit-serial 1000 / rate) and the next-run time, pushes to the queue
// ---------------------------------------------------------------------------
module gfes_front
	import gfes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [GRP_W-1:0]  group_index,
	input  logic [KIND_W-1:0] effect_kind,
	input  logic [TIME_W-1:0] delay_ms,
	input  logic [PER_W-1:0]  rate_hz,
	input  logic [LVL_W-1:0]  level_value,
	input  logic              on_value,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [PER_W-1:0]  default_period,
	output logic              push,
	output cmd_t              push_cmd,
	input  logic              q_full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	localparam int DCNT_W = $clog2(PER_W);

	logic [1:0]        state_q;
	cmd_t              cmd_q;
	logic [PER_W-1:0]  div_q;
	logic [PER_W-1:0]  rem_q;
	logic [PER_W-1:0]  dvd_q;
	logic [DCNT_W-1:0] cnt_q;

	logic             accept;
	logic             grp_ok;
	logic             drop;
	logic             need_div;
	logic             is_fade;
	logic [PER_W:0]   trial;
	logic             ge;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign push     = (state_q == F_PUSH) && !q_full;
	assign push_cmd = cmd_q;

	always_comb begin
		grp_ok   = (32'(group_index) < NUM_GROUPS);
		drop     = !(func == FUNC_TICK || func == FUNC_APPLY || func == FUNC_SET) ||
		           ((func != FUNC_TICK) && !grp_ok);
		need_div = (func == FUNC_APPLY) && (effect_kind != KIND_NONE) && (rate_hz != '0);
		is_fade  = (effect_kind == KIND_UP) || (effect_kind == KIND_DOWN);
		trial    = {rem_q, dvd_q[PER_W-1]};
		ge       = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && !drop) begin
						state_q <= need_div ? F_DIV : F_PUSH;
					end
				end
				F_DIV: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op    <= func;
			cmd_q.grp   <= group_index;
			cmd_q.kind  <= effect_kind;
			cmd_q.level <= level_value;
			cmd_q.on    <= on_value;
			if (func == FUNC_APPLY) begin
				cmd_q.stamp <= is_fade ? (now_ms + delay_ms) : '0;
			end else begin
				cmd_q.stamp <= now_ms;
			end
			if (effect_kind == KIND_NONE || need_div) begin
				cmd_q.period <= '0;
			end else begin
				cmd_q.period <= default_period;
			end
			div_q <= rate_hz;
			rem_q <= '0;
			dvd_q <= PER_W'(MS_PER_S);
			cnt_q <= DCNT_W'(PER_W - 1);
		end else if (state_q == F_DIV) begin
			// restoring divide, one quotient bit per cycle
			rem_q        <= ge ? PER_W'(trial - {1'b0, div_q}) : trial[PER_W-1:0];
			dvd_q        <= {dvd_q[PER_W-2:0], 1'b0};
			cmd_q.period <= {cmd_q.period[PER_W-2:0], ge};
			cnt_q        <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/gfes_queue.sv */
// ---------------------------------------------------------------------------
// gfes_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
module gfes_queue
	import gfes_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/gfes_back.sv */
// ---------------------------------------------------------------------------
// gfes_back
// holds the group table, carries out apply and set level, and scans the
// groups one per cycle on a tick, stalling while the result path is full,
// with one result held back to mark the last
module gfes_back
	import gfes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [GRP_W-1:0] out_group,
	output logic [LVL_W-1:0] out_level,
	output logic             out_on,
	output logic             last
);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_SCAN  = 2'd1;
	localparam logic [1:0] B_FLUSH = 2'd2;

	// group table
	logic [KIND_W-1:0] kind_q [NUM_GROUPS];
	logic [TIME_W-1:0] next_q [NUM_GROUPS];
	logic [PER_W-1:0]  per_q  [NUM_GROUPS];
	logic [LVL_W-1:0]  lvl_q  [NUM_GROUPS];
	logic              on_q   [NUM_GROUPS];

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] now_q;

	// held-back result
	logic              pend_valid_q;
	logic [GRP_W-1:0]  pend_grp_q;
	logic [LVL_W-1:0]  pend_lvl_q;
	logic              pend_on_q;

	// output register
	logic              out_valid_q;
	logic [GRP_W-1:0]  out_grp_q;
	logic [LVL_W-1:0]  out_lvl_q;
	logic              out_on_q;
	logic              out_last_q;

	logic [KIND_W-1:0] cur_kind;
	logic [LVL_W-1:0]  cur_lvl;
	logic              due;
	logic              capped;
	logic              out_free;
	logic              room;
	logic              step;
	logic              out_load;
	logic [LVL_W-1:0]  new_lvl;
	logic              new_on;
	logic              done;
	logic              at_end;
	logic [IDX_W-1:0]  wr_idx;

	assign out_valid = out_valid_q;
	assign out_group = out_grp_q;
	assign out_level = out_lvl_q;
	assign out_on    = out_on_q;
	assign last      = out_last_q;

	assign pop = (state_q == B_IDLE) && !empty;

	always_comb begin
		cur_kind = kind_q[idx_q];
		cur_lvl  = lvl_q[idx_q];
		due      = ((cur_kind == KIND_UP) || (cur_kind == KIND_DOWN)) &&
		           (now_q >= next_q[idx_q]);
		capped   = (cnt_q == CNT_W'(MAX_RESULTS));
		out_free = !out_valid_q || out_ready;
		room     = !pend_valid_q || out_free;
		step     = (state_q == B_SCAN) && due && !capped && room;
		out_load = (step && pend_valid_q) ||
		           ((state_q == B_FLUSH) && pend_valid_q && out_free);
		at_end   = (idx_q == IDX_W'(NUM_GROUPS - 1));
		wr_idx   = IDX_W'(head.grp);
		if (cur_kind == KIND_UP) begin
			new_lvl = (cur_lvl != LVL_W'(FULL_LEVEL)) ? cur_lvl + 1'b1 : cur_lvl;
			new_on  = 1'b1;
			done    = (new_lvl == LVL_W'(FULL_LEVEL));
		end else begin
			new_lvl = (cur_lvl != '0) ? cur_lvl - 1'b1 : cur_lvl;
			new_on  = (new_lvl != '0);
			done    = (new_lvl == '0);
		end
	end

	// group table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				kind_q[g] <= KIND_NONE;
				next_q[g] <= '0;
				per_q[g]  <= '0;
				lvl_q[g]  <= '0;
				on_q[g]   <= 1'b0;
			end
		end else if (pop) begin
			case (head.op)
				FUNC_APPLY: begin
					kind_q[wr_idx] <= head.kind;
					next_q[wr_idx] <= head.stamp;
					per_q[wr_idx]  <= head.period;
				end
				FUNC_SET: begin
					lvl_q[wr_idx] <= head.level;
					on_q[wr_idx]  <= head.on;
				end
				default: ;
			endcase
		end else if (step) begin
			lvl_q[idx_q] <= new_lvl;
			on_q[idx_q]  <= new_on;
			if (done) begin
				kind_q[idx_q] <= KIND_NONE;
				next_q[idx_q] <= '0;
				per_q[idx_q]  <= '0;
			end else begin
				next_q[idx_q] <= now_q + TIME_W'(per_q[idx_q]);
			end
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop && head.op == FUNC_TICK) begin
						state_q <= B_SCAN;
						idx_q   <= '0;
						cnt_q   <= '0;
					end
				end
				B_SCAN: begin
					if (due && capped) begin
						state_q <= B_FLUSH;
					end else if (!due || room) begin
						if (step) begin
							cnt_q        <= cnt_q + 1'b1;
							pend_valid_q <= 1'b1;
						end
						if (at_end) begin
							state_q <= B_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				B_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= B_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && head.op == FUNC_TICK) begin
			now_q <= head.stamp;
		end
		if (step) begin
			pend_grp_q <= GRP_W'(idx_q);
			pend_lvl_q <= new_lvl;
			pend_on_q  <= new_on;
			if (pend_valid_q) begin
				out_grp_q  <= pend_grp_q;
				out_lvl_q  <= pend_lvl_q;
				out_on_q   <= pend_on_q;
				out_last_q <= 1'b0;
			end
		end else if (state_q == B_FLUSH && pend_valid_q && out_free) begin
			out_grp_q  <= pend_grp_q;
			out_lvl_q  <= pend_lvl_q;
			out_on_q   <= pend_on_q;
			out_last_q <= 1'b1;
		end
	end

endmodule

/* sim/fade_step_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fade_step_checker
// watches the request and result channels of the group fade effect
// scheduler, keeps its own copy of the group table, predicts the fade
// steps every tick causes and compares each result against the oldest one
// ---------------------------------------------------------------------------
module fade_step_checker
	import gfes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PER_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [GRP_W-1:0]  group_index,
	input  logic [KIND_W-1:0] effect_kind,
	input  logic [TIME_W-1:0] delay_ms,
	input  logic [PER_W-1:0]  rate_hz,
	input  logic [LVL_W-1:0]  level_value,
	input  logic              on_value,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [GRP_W-1:0]  out_group,
	input  logic [LVL_W-1:0]  out_level,
	input  logic              out_on,
	input  logic              last,
	output int                mismatches,
	output int                steps_pending
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [GRP_W-1:0] grp;
		logic [LVL_W-1:0] level;
		logic             on;
		logic             is_last;
	} fade_step_t;

	fade_step_t        due_steps_q[$];

	logic [KIND_W-1:0] grp_kind   [NUM_GROUPS];
	logic [TIME_W-1:0] grp_next   [NUM_GROUPS];
	logic [PER_W-1:0]  grp_period [NUM_GROUPS];
	logic [LVL_W-1:0]  grp_level  [NUM_GROUPS];
	logic              grp_on     [NUM_GROUPS];
	logic [PER_W-1:0]  dflt_period;

	always @(posedge clk or negedge arst_n) begin : track
		fade_step_t       got;
		fade_step_t       want;
		logic [LVL_W-1:0] lvl;
		int               steps_made;
		int               quot;
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_kind[g]   = KIND_NONE;
				grp_next[g]   = '0;
				grp_period[g] = '0;
				grp_level[g]  = '0;
				grp_on[g]     = 1'b0;
			end
			dflt_period = RESET_PERIOD;
			due_steps_q.delete();
			mismatches = 0;
		end else begin
			// results leaving now were predicted at an earlier edge
			if (out_valid && out_ready) begin
				got = {out_group, out_level, out_on, last};
				if (due_steps_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%t unexpected result: group %0d level %0d on %0b last %0b",
							$realtime, got.grp, got.level, got.on, got.is_last);
					mismatches++;
				end else begin
					want = due_steps_q.pop_front();
					if (got != want) begin
						if (mismatches < MAX_REPORTS) begin
							$write("%t step mismatch: expected group %0d level %0d on %0b last %0b",
								$realtime, want.grp, want.level, want.on, want.is_last);
							$display(", got group %0d level %0d on %0b last %0b",
								got.grp, got.level, got.on, got.is_last);
						end
						mismatches++;
					end
				end
			end

			if (in_valid && in_ready) begin
				case (func)
					FUNC_TICK: begin
						steps_made = 0;
						for (int g = 0; g < NUM_GROUPS; g++) begin
							if ((grp_kind[g] == KIND_UP || grp_kind[g] == KIND_DOWN) &&
								now_ms >= grp_next[g]) begin
								grp_next[g] = now_ms + TIME_W'(grp_period[g]);
								lvl = grp_level[g];
								grp_on[g] = 1'b1;
								if (grp_kind[g] == KIND_UP) begin
									if (lvl != LVL_W'(FULL_LEVEL))
										lvl = lvl + 1'b1;
									if (lvl == LVL_W'(FULL_LEVEL)) begin
										grp_kind[g]   = KIND_NONE;
										grp_next[g]   = '0;
										grp_period[g] = '0;
									end
								end else begin
									if (lvl != '0)
										lvl = lvl - 1'b1;
									if (lvl == '0) begin
										grp_kind[g]   = KIND_NONE;
										grp_next[g]   = '0;
										grp_period[g] = '0;
										grp_on[g]     = 1'b0;
									end
								end
								grp_level[g] = lvl;
								want.grp     = g[GRP_W-1:0];
								want.level   = lvl;
								want.on      = grp_on[g];
								want.is_last = 1'b0;
								due_steps_q.push_back(want);
								steps_made++;
							end
						end
						if (steps_made > 0)
							due_steps_q[due_steps_q.size() - 1].is_last = 1'b1;
					end
					FUNC_APPLY: begin
						grp_kind[group_index]   = KIND_NONE;
						grp_next[group_index]   = '0;
						grp_period[group_index] = '0;
						if (effect_kind != KIND_NONE) begin
							grp_kind[group_index] = effect_kind;
							if (rate_hz != '0) begin
								quot = MS_PER_S / int'(rate_hz);
								grp_period[group_index] = quot[PER_W-1:0];
							end else begin
								grp_period[group_index] = dflt_period;
							end
							// strobe keeps next-run time zero and is never stepped
							if (effect_kind == KIND_UP || effect_kind == KIND_DOWN)
								grp_next[group_index] = now_ms + delay_ms;
						end
					end
					FUNC_SET: begin
						grp_level[group_index] = level_value;
						grp_on[group_index]    = on_value;
					end
					default: ;
				endcase
			end

			if (cfg_we)
				dflt_period = cfg_wdata;
		end
		steps_pending = due_steps_q.size();
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives apply, set level and tick requests into the group fade effect
// scheduler through a directed opening and four randomized phases with
// different idling on both channels and different default periods; the
// checker beside the block predicts every fade step and counts mismatches
// ---------------------------------------------------------------------------
module testbench;
	import gfes_pkg::*;

	localparam int               CLK_HALF      = 5;
	localparam int               SETTLE_CYCLES = 200;       // a few queued ticks with no steps
	localparam int               HOLD_CYCLES   = 400;       // long result hold-off
	localparam int               PHASE_ITEMS   = 44;
	localparam int               TIMEOUT_NS    = 5_000_000;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;      // no-op code

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [PER_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [FUNC_W-1:0] func;
	logic [GRP_W-1:0]  group_index;
	logic [KIND_W-1:0] effect_kind;
	logic [TIME_W-1:0] delay_ms;
	logic [PER_W-1:0]  rate_hz;
	logic [LVL_W-1:0]  level_value;
	logic              on_value;
	logic [TIME_W-1:0] now_ms;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [GRP_W-1:0]  out_group;
	logic [LVL_W-1:0]  out_level;
	logic              out_on;
	logic              last;

	int                mismatches;
	int                steps_pending;

	// stimulus knobs and counters; the knobs change only between phases
	int                send_gap_pct = 0;
	int                stall_pct    = 0;
	int                requests_sent = 0;
	logic [TIME_W-1:0] cur_now = '0;

	// long receiver hold-off: armed by the stimulus, counted by the receiver
	logic              hold_armed = 1'b0;
	logic              hold_done  = 1'b0;
	int                hold_count = 0;

	always #(CLK_HALF) clk = ~clk;

	group_fade_effect_scheduler_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.group_index (group_index),
		.effect_kind (effect_kind),
		.delay_ms    (delay_ms),
		.rate_hz     (rate_hz),
		.level_value (level_value),
		.on_value    (on_value),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_group   (out_group),
		.out_level   (out_level),
		.out_on      (out_on),
		.last        (last)
	);

	fade_step_checker fade_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.group_index   (group_index),
		.effect_kind   (effect_kind),
		.delay_ms      (delay_ms),
		.rate_hz       (rate_hz),
		.level_value   (level_value),
		.on_value      (on_value),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_group     (out_group),
		.out_level     (out_level),
		.out_on        (out_on),
		.last          (last),
		.mismatches    (mismatches),
		.steps_pending (steps_pending)
	);

	// result side: random stalls, or the one long hold-off once armed
	always @(negedge clk) begin
		if (hold_armed && !hold_done) begin
			out_ready  <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one request: optional idle gap, then hold valid until the block takes it
	task automatic push_request(
		input logic [FUNC_W-1:0] f,
		input logic [GRP_W-1:0]  grp,
		input logic [KIND_W-1:0] kind,
		input logic [TIME_W-1:0] delay,
		input logic [PER_W-1:0]  rate,
		input logic [LVL_W-1:0]  lvl,
		input logic              on,
		input logic [TIME_W-1:0] now
	);
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		func        <= f;
		group_index <= grp;
		effect_kind <= kind;
		delay_ms    <= delay;
		rate_hz     <= rate;
		level_value <= lvl;
		on_value    <= on;
		now_ms      <= now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// unused fields of each request carry random values
	task automatic send_tick(input logic [TIME_W-1:0] now);
		push_request(FUNC_TICK, GRP_W'($urandom), KIND_W'($urandom), $urandom,
			PER_W'($urandom_range(MS_PER_S)), LVL_W'($urandom), 1'($urandom), now);
	endtask

	task automatic send_apply(input logic [GRP_W-1:0] grp, input logic [KIND_W-1:0] kind,
		input logic [TIME_W-1:0] delay, input logic [PER_W-1:0] rate);
		push_request(FUNC_APPLY, grp, kind, delay, rate, LVL_W'($urandom), 1'($urandom),
			cur_now);
	endtask

	task automatic send_level(input logic [GRP_W-1:0] grp, input logic [LVL_W-1:0] lvl,
		input logic on);
		push_request(FUNC_SET, grp, KIND_W'($urandom), $urandom,
			PER_W'($urandom_range(MS_PER_S)), lvl, on, $urandom);
	endtask

	// levels lean toward both ends so saturation comes up often
	function automatic logic [LVL_W-1:0] pick_level();
		case ($urandom_range(3))
			0:       return LVL_W'($urandom_range(3));
			1:       return LVL_W'($urandom_range(FULL_LEVEL - 3, FULL_LEVEL));
			default: return LVL_W'($urandom_range(FULL_LEVEL));
		endcase
	endfunction

	// zero picks the default period, high rates give short periods
	function automatic logic [PER_W-1:0] pick_rate();
		case ($urandom_range(2))
			0:       return '0;
			1:       return PER_W'($urandom_range(200, MS_PER_S));
			default: return PER_W'($urandom_range(1, MS_PER_S));
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] advance_now();
		cur_now = cur_now + $urandom_range(12);
		return cur_now;
	endfunction

	// stop sending, let every predicted step come out, then let the block settle
	task automatic wait_drained(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (steps_pending != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_period(input logic [PER_W-1:0] period);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= period;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly well-formed fade sequences with random content, some noise
	task automatic run_random(input int count);
		int stop_at;
		int pick;
		int first;
		int n;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				// one group: maybe load a level, start a fade, tick a few times
				first = $urandom_range(NUM_GROUPS - 1);
				if ($urandom_range(1))
					send_level(GRP_W'(first), pick_level(), 1'($urandom_range(1)));
				send_apply(GRP_W'(first), $urandom_range(1) ? KIND_UP : KIND_DOWN,
					$urandom_range(20), pick_rate());
				repeat ($urandom_range(1, 4)) send_tick(advance_now());
			end else if (pick < 60) begin
				// many groups due at the same tick, sometimes all of them
				first = $urandom_range(NUM_GROUPS - 1);
				n = ($urandom_range(2) == 0) ? NUM_GROUPS : $urandom_range(4, 8);
				for (int k = 0; k < n; k++)
					send_apply(GRP_W'(first + k), $urandom_range(1) ? KIND_UP : KIND_DOWN,
						'0, PER_W'($urandom_range(500, MS_PER_S)));
				send_tick(cur_now);
				repeat ($urandom_range(1, 3)) send_tick(advance_now());
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3)) send_tick(advance_now());
			end else if (pick < 88) begin
				// cancel or strobe: both stop a group from stepping
				send_apply(GRP_W'($urandom_range(NUM_GROUPS - 1)),
					$urandom_range(1) ? KIND_NONE : KIND_STROBE, $urandom, pick_rate());
			end else begin
				// noise: random fields under a valid func code, time jumps included
				push_request(FUNC_W'($urandom_range(FUNC_SET)), GRP_W'($urandom),
					KIND_W'($urandom), $urandom, PER_W'($urandom_range(MS_PER_S)),
					LVL_W'($urandom), 1'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		func        = FUNC_TICK;
		group_index = '0;
		effect_kind = KIND_NONE;
		delay_ms    = '0;
		rate_hz     = '0;
		level_value = '0;
		on_value    = 1'b0;
		now_ms      = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed opening, reset default period of 16 ms
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, '0);      // nothing active
		push_request(FUNC_SET,   4'd0,  KIND_NONE,   '0, '0, 8'd253, 1'b0, '0);
		push_request(FUNC_APPLY, 4'd0,  KIND_UP,     '0, 10'd1000, '0, 1'b0, '0);  // period 1
		push_request(FUNC_SET,   4'd15, KIND_NONE,   '0, '0, 8'd1, 1'b1, '0);
		push_request(FUNC_APPLY, 4'd15, KIND_DOWN,   32'd5, '0, '0, 1'b0, '0);   // default period
		push_request(FUNC_APPLY, 4'd7,  KIND_STROBE, '1, 10'd1, '0, 1'b0, '0);   // stored, inert
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd0);
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd1);   // up reaches full
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd5);   // down reaches zero
		push_request(FUNC_SET,   4'd3,  KIND_NONE,   '0, '0, 8'd0, 1'b1, '0);
		push_request(FUNC_APPLY, 4'd3,  KIND_DOWN,   '0, 10'd500, '0, 1'b0, 32'd10);
		push_request(FUNC_SET,   4'd4,  KIND_NONE,   '0, '0, 8'd255, 1'b0, '0);
		push_request(FUNC_APPLY, 4'd4,  KIND_UP,     '0, 10'd3, '0, 1'b0, 32'd10);
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd10);  // both already saturated
		push_request(FUNC_APPLY, 4'd5,  KIND_UP,     '0, '0, '0, 1'b0, 32'd10);
		push_request(FUNC_APPLY, 4'd5,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd10);  // cancel
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd20);
		push_request(FUNC_UNUSED, '1,   '1,          '1, '1, '1, 1'b1, '1);      // ignored code
		push_request(FUNC_SET,   4'd8,  KIND_NONE,   '0, '0, 8'd0, 1'b0, '0);
		push_request(FUNC_APPLY, 4'd8,  KIND_UP,     '1, 10'd1000, '0, 1'b0, 32'hFFFF_FFF0);
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, '1);      // next-run time wrapped
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd0);   // now wrapped too
		push_request(FUNC_APPLY, 4'd9,  KIND_DOWN,   '0, 10'd1000, '0, 1'b0, 32'd0);
		push_request(FUNC_TICK,  4'd0,  KIND_NONE,   '0, '0, '0, 1'b0, 32'd100); // two steps, last on 2nd
		wait_drained(SETTLE_CYCLES);

		// phase a: shortest default period, no idling anywhere
		write_period(10'd1);
		cur_now = $urandom;
		run_random(PHASE_ITEMS);
		wait_drained(SETTLE_CYCLES);

		// phase b: longest default period, sender mostly idle, time wraps
		write_period(10'd1000);
		send_gap_pct = 66;
		stall_pct    = 0;
		cur_now      = 32'hFFFF_FF00;
		run_random(PHASE_ITEMS);
		wait_drained(SETTLE_CYCLES);

		// phase c: receiver mostly stalled, with one long hold-off that fills the block
		write_period(PER_W'($urandom_range(2, 999)));
		send_gap_pct = 0;
		stall_pct    = 66;
		cur_now      = $urandom;
		run_random(10);
		hold_armed = 1'b1;
		run_random(PHASE_ITEMS - 10);
		wait_drained(SETTLE_CYCLES);

		// phase d: both sides idle a third of the time, sender pauses midway
		write_period(10'd22);
		send_gap_pct = 33;
		stall_pct    = 33;
		cur_now      = $urandom;
		run_random(PHASE_ITEMS / 2);
		wait_drained(0);
		run_random(PHASE_ITEMS / 2);
		wait_drained(SETTLE_CYCLES);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
